### rtl/qpid_pkg.sv
// Shared types, widths, codes and reset values for the three-axis PID mixer.
// Used by the channel interfaces, the lanes, the mixer and the top level.
`timescale 1ns / 1ps

package qpid_pkg;

  localparam int NUM_AXES  = 3;
  localparam int GAIN_W    = 16;
  localparam int MEAS_W    = 16;
  localparam int ERR_W     = MEAS_W + 1;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int SUM_W     = 32;
  localparam int CORR_W    = 12;
  localparam int MOTOR_W   = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam int PROD_P_W  = GAIN_W + 1 + ERR_W;
  localparam int PROD_I_W  = GAIN_W + 1 + SUM_W;
  localparam int PROD_D_W  = GAIN_W + 1 + DIFF_W;
  localparam int RAW_W     = PROD_I_W + 1;
  localparam int FRAC_W    = 8 + 8;
  localparam int Q_W       = RAW_W - FRAC_W;
  localparam int MIX_W     = MOTOR_W + 3;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_INTEG_GAIN = 3'd1,
    CFG_DERIV_GAIN = 3'd2,
    CFG_OUT_LOW    = 3'd3,
    CFG_OUT_HIGH   = 3'd4,
    CFG_MOTOR_LOW  = 3'd5,
    CFG_MOTOR_HIGH = 3'd6
  } cfg_index_t;

  localparam logic [GAIN_W-1:0]         PROP_GAIN_RST  = 16'd256;
  localparam logic [GAIN_W-1:0]         INTEG_GAIN_RST = 16'd0;
  localparam logic [GAIN_W-1:0]         DERIV_GAIN_RST = 16'd1280;
  localparam logic signed [CORR_W-1:0]  OUT_LOW_RST    = -12'sd500;
  localparam logic signed [CORR_W-1:0]  OUT_HIGH_RST   = 12'sd500;
  localparam logic [MOTOR_W-1:0]        MOTOR_LOW_RST  = 12'd1000;
  localparam logic [MOTOR_W-1:0]        MOTOR_HIGH_RST = 12'd2000;

  typedef struct packed {
    logic [GAIN_W-1:0]        prop_gain;
    logic [GAIN_W-1:0]        integ_gain;
    logic [GAIN_W-1:0]        deriv_gain;
    logic signed [CORR_W-1:0] out_low;
    logic signed [CORR_W-1:0] out_high;
  } gains_t;

  typedef struct packed {
    logic [MOTOR_W-1:0] low;
    logic [MOTOR_W-1:0] high;
  } motor_lim_t;

  // take: an item enters the lane front (state update); adv: pipeline moves
  typedef struct packed {
    logic take;
    logic adv;
  } lane_ctl_t;

  typedef struct packed {
    logic [MOTOR_W-1:0]       motor_front_left;
    logic [MOTOR_W-1:0]       motor_front_right;
    logic [MOTOR_W-1:0]       motor_rear_right;
    logic [MOTOR_W-1:0]       motor_rear_left;
    logic signed [CORR_W-1:0] pitch_trim;
    logic signed [CORR_W-1:0] roll_trim;
    logic signed [CORR_W-1:0] yaw_trim;
  } out_data_t;

endpackage

### rtl/qpid_if.sv
// Valid/ready channel interfaces for the measurement input and motor result.
// Depends on qpid_pkg for field widths.
`timescale 1ns / 1ps

interface qpid_in_if import qpid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MOTOR_W-1:0]       throttle;
  logic signed [MEAS_W-1:0] pitch_angle;
  logic signed [MEAS_W-1:0] roll_angle;
  logic signed [MEAS_W-1:0] yaw_rate;

  modport source (output valid, throttle, pitch_angle, roll_angle, yaw_rate,
                  input ready);
  modport sink   (input valid, throttle, pitch_angle, roll_angle, yaw_rate,
                  output ready);
endinterface

interface qpid_out_if import qpid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MOTOR_W-1:0]       motor_front_left;
  logic [MOTOR_W-1:0]       motor_front_right;
  logic [MOTOR_W-1:0]       motor_rear_right;
  logic [MOTOR_W-1:0]       motor_rear_left;
  logic signed [CORR_W-1:0] pitch_trim;
  logic signed [CORR_W-1:0] roll_trim;
  logic signed [CORR_W-1:0] yaw_trim;

  modport source (output valid, motor_front_left, motor_front_right,
                  motor_rear_right, motor_rear_left, pitch_trim,
                  roll_trim, yaw_trim,
                  input ready);
  modport sink   (input valid, motor_front_left, motor_front_right,
                  motor_rear_right, motor_rear_left, pitch_trim,
                  roll_trim, yaw_trim,
                  output ready);
endinterface

### rtl/qpid_lane.sv
// One PID lane: integral and last-error state, three-stage datapath
// (error/integral, gain products, sum/floor/clamp). Depends on qpid_pkg.
`timescale 1ns / 1ps

module qpid_lane import qpid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  lane_ctl_t                ctl,
  input  gains_t                   gains,
  input  logic signed [MEAS_W-1:0] meas,
  output logic signed [CORR_W-1:0] corr
);

  logic signed [SUM_W-1:0]    error_sum;
  logic signed [ERR_W-1:0]    last_error;

  logic signed [ERR_W-1:0]    err;
  logic signed [SUM_W:0]      sum_ext;
  logic signed [SUM_W-1:0]    sum_sat;
  logic signed [DIFF_W-1:0]   diff;

  logic signed [ERR_W-1:0]    err_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic signed [DIFF_W-1:0]   diff_q;

  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;

  logic signed [RAW_W-1:0]    raw;
  logic signed [Q_W-1:0]      q_floor;
  logic signed [Q_W-1:0]      lim_hi;
  logic signed [Q_W-1:0]      lim_lo;
  logic signed [Q_W-1:0]      c_hi;
  logic signed [Q_W-1:0]      c_lo;

  // setpoint is zero: error is the negated measurement
  assign err     = {ERR_W{1'b0}} - {meas[MEAS_W-1], meas};
  assign sum_ext = {error_sum[SUM_W-1], error_sum} +
                   {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
  assign sum_sat = (sum_ext[SUM_W] != sum_ext[SUM_W-1])
                 ? (sum_ext[SUM_W] ? SUM_MIN : SUM_MAX)
                 : sum_ext[SUM_W-1:0];
  assign diff    = {err[ERR_W-1], err} - {last_error[ERR_W-1], last_error};

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (ctl.take) begin
      error_sum  <= sum_sat;
      last_error <= err;
    end
  end

  // Q8.8 gain times Q8.8 value gives Q16.16; floor is an arithmetic shift
  assign raw = {{(RAW_W-PROD_P_W){prod_p[PROD_P_W-1]}}, prod_p} +
               {{(RAW_W-PROD_I_W){prod_i[PROD_I_W-1]}}, prod_i} +
               {{(RAW_W-PROD_D_W){prod_d[PROD_D_W-1]}}, prod_d};
  assign q_floor = raw[RAW_W-1:FRAC_W];
  assign lim_hi  = {{(Q_W-CORR_W){gains.out_high[CORR_W-1]}}, gains.out_high};
  assign lim_lo  = {{(Q_W-CORR_W){gains.out_low[CORR_W-1]}}, gains.out_low};
  // high clamp first, low clamp last
  assign c_hi    = (q_floor > lim_hi) ? lim_hi : q_floor;
  assign c_lo    = (c_hi < lim_lo) ? lim_lo : c_hi;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      err_q  <= err;
      sum_q  <= sum_sat;
      diff_q <= diff;
      prod_p <= $signed({1'b0, gains.prop_gain}) * err_q;
      prod_i <= $signed({1'b0, gains.integ_gain}) * sum_q;
      prod_d <= $signed({1'b0, gains.deriv_gain}) * diff_q;
      corr   <= c_lo[CORR_W-1:0];
    end
  end

endmodule

### rtl/qpid_mix.sv
// X-frame motor mixer: combines throttle with the three lane corrections
// and clamps each motor to the configured range. Depends on qpid_pkg.
`timescale 1ns / 1ps

module qpid_mix import qpid_pkg::*; (
  input  logic [MOTOR_W-1:0]       throttle,
  input  logic signed [CORR_W-1:0] pitch,
  input  logic signed [CORR_W-1:0] roll,
  input  logic signed [CORR_W-1:0] yaw,
  input  motor_lim_t               lim,
  output out_data_t                data
);

  logic signed [MIX_W-1:0] thr;
  logic signed [MIX_W-1:0] p;
  logic signed [MIX_W-1:0] r;
  logic signed [MIX_W-1:0] y;
  logic signed [MIX_W-1:0] lo;
  logic signed [MIX_W-1:0] hi;

  // low clamp first, high clamp last
  function automatic logic [MOTOR_W-1:0] motor_clamp(
    input logic signed [MIX_W-1:0] v,
    input logic signed [MIX_W-1:0] lo_v,
    input logic signed [MIX_W-1:0] hi_v
  );
    logic signed [MIX_W-1:0] t;
    t = (v < lo_v) ? lo_v : v;
    t = (t > hi_v) ? hi_v : t;
    return t[MOTOR_W-1:0];
  endfunction

  assign thr = {{(MIX_W-MOTOR_W){1'b0}}, throttle};
  assign p   = {{(MIX_W-CORR_W){pitch[CORR_W-1]}}, pitch};
  assign r   = {{(MIX_W-CORR_W){roll[CORR_W-1]}}, roll};
  assign y   = {{(MIX_W-CORR_W){yaw[CORR_W-1]}}, yaw};
  assign lo  = {{(MIX_W-MOTOR_W){1'b0}}, lim.low};
  assign hi  = {{(MIX_W-MOTOR_W){1'b0}}, lim.high};

  always_comb begin
    data.motor_front_left  = motor_clamp(thr - p - r - y, lo, hi);
    data.motor_front_right = motor_clamp(thr - p + r + y, lo, hi);
    data.motor_rear_right  = motor_clamp(thr + p + r - y, lo, hi);
    data.motor_rear_left   = motor_clamp(thr + p - r + y, lo, hi);
    data.pitch_trim        = pitch;
    data.roll_trim         = roll;
    data.yaw_trim          = yaw;
  end

endmodule

### rtl/three_axis_pid_quad_x_mixer.sv
// Three-axis PID stabilizer with X-frame quad motor mixer (top level).
// Pipeline: the lane stages load at the input transfer edge, then products, then
// sum/floor/clamp; the mixer feeds the output register. Throughput: one item per
// cycle while the output does not stall; the integral/last-error write-back
// completes in the accept cycle. Output stalls hold the lanes.
// Reset (rst, synchronous): gains/limits to defaults, integrals and last errors
// to zero, pipeline and output empty. Depends on qpid_pkg, qpid_if, qpid_lane, qpid_mix.
`timescale 1ns / 1ps

module three_axis_pid_quad_x_mixer import qpid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  qpid_in_if.sink              in_ch,
  qpid_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers. The user must write them only while the block is
  // idle; the block itself does not enforce it. The lanes and mixer read them live.
  // ---------------------------------------------------------------------
  gains_t     gains;
  motor_lim_t motor_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop_gain  <= PROP_GAIN_RST;
      gains.integ_gain <= INTEG_GAIN_RST;
      gains.deriv_gain <= DERIV_GAIN_RST;
      gains.out_low    <= OUT_LOW_RST;
      gains.out_high   <= OUT_HIGH_RST;
      motor_lim.low    <= MOTOR_LOW_RST;
      motor_lim.high   <= MOTOR_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROP_GAIN:  gains.prop_gain  <= cfg_data;
        CFG_INTEG_GAIN: gains.integ_gain <= cfg_data;
        CFG_DERIV_GAIN: gains.deriv_gain <= cfg_data;
        CFG_OUT_LOW:    gains.out_low    <= cfg_data[CORR_W-1:0];
        CFG_OUT_HIGH:   gains.out_high   <= cfg_data[CORR_W-1:0];
        CFG_MOTOR_LOW:  motor_lim.low    <= cfg_data[MOTOR_W-1:0];
        CFG_MOTOR_HIGH: motor_lim.high   <= cfg_data[MOTOR_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Flow control. The whole lane pipeline advances together whenever the
  // skid register is empty. The skid register catches the one item that may
  // leave the pipeline in the cycle the output stalls, so in_ch.ready is a
  // flop and never depends combinationally on out_ch.ready.
  // ---------------------------------------------------------------------
  logic      adv;
  logic      take;
  logic      v1, v2, v3;
  logic [MOTOR_W-1:0] thr1, thr2, thr3;
  lane_ctl_t ctl;

  logic      out_valid;
  logic      skid_valid;
  out_data_t out_data;
  out_data_t skid_data;
  out_data_t mix_data;
  logic      pop;
  logic      arrive;

  assign adv          = !skid_valid;
  assign in_ch.ready  = adv;
  assign take         = in_ch.valid && adv;
  assign ctl.take     = take;
  assign ctl.adv      = adv;
  assign pop          = out_valid && out_ch.ready;
  assign arrive       = adv && v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // throttle rides alongside the lane stages
  always_ff @(posedge clk) begin
    if (adv) begin
      thr1 <= in_ch.throttle;
      thr2 <= thr1;
      thr3 <= thr2;
    end
  end

  // ---------------------------------------------------------------------
  // Three parallel PID lanes: pitch, roll, yaw.
  // ---------------------------------------------------------------------
  logic signed [MEAS_W-1:0] meas [NUM_AXES];
  logic signed [CORR_W-1:0] corr [NUM_AXES];

  assign meas[0] = in_ch.pitch_angle;
  assign meas[1] = in_ch.roll_angle;
  assign meas[2] = in_ch.yaw_rate;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    qpid_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .gains (gains),
      .meas  (meas[a]),
      .corr  (corr[a])
    );
  end

  // merge stage: corrections into four motor commands
  qpid_mix u_mix (
    .throttle (thr3),
    .pitch    (corr[0]),
    .roll     (corr[1]),
    .yaw      (corr[2]),
    .lim      (motor_lim),
    .data     (mix_data)
  );

  // ---------------------------------------------------------------------
  // Output register plus skid register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop || !out_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (arrive) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop || !out_valid) begin
        out_data <= skid_data;
      end
    end else if (arrive) begin
      if (!out_valid || pop) begin
        out_data <= mix_data;
      end else begin
        skid_data <= mix_data;
      end
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.motor_front_left  = out_data.motor_front_left;
  assign out_ch.motor_front_right = out_data.motor_front_right;
  assign out_ch.motor_rear_right  = out_data.motor_rear_right;
  assign out_ch.motor_rear_left   = out_data.motor_rear_left;
  assign out_ch.pitch_trim        = out_data.pitch_trim;
  assign out_ch.roll_trim         = out_data.roll_trim;
  assign out_ch.yaw_trim          = out_data.yaw_trim;

endmodule

### dv/tb_three_axis_pid_quad_x_mixer.sv
// Self-checking testbench for the three-axis PID stabilizer with X-frame motor mixer.
// Runs a directed table, random register segments and a back-to-back run with no idling.
// Depends on qpid_pkg, qpid_if and the RTL top three_axis_pid_quad_x_mixer.
`timescale 1ns / 1ps

module tb_three_axis_pid_quad_x_mixer;
  import qpid_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 6;
  // let the pipeline settle before touching registers
  localparam int SETTLE_CYCLES = 8;
  // longest stretch with no transfer at all before the run is declared hung
  localparam int QUIET_LIMIT   = 2000;
  localparam int IDLE_PCT      = 31;
  localparam int RAND_SEGMENTS = 8;
  localparam int SEGMENT_ITEMS = 150;
  // full-scale pitch and roll build up the integrals, then the signs flip
  localparam int SOAK_ITEMS    = 160;
  localparam int UNWIND_ITEMS  = 32;
  localparam int DIR_ROWS      = 24;

  typedef struct packed {
    logic [MOTOR_W-1:0]       throttle;
    logic signed [MEAS_W-1:0] pitch;
    logic signed [MEAS_W-1:0] roll;
    logic signed [MEAS_W-1:0] yaw;
  } sample_t;

  // shadow of the register file
  typedef struct packed {
    logic [GAIN_W-1:0]        kp;
    logic [GAIN_W-1:0]        ki;
    logic [GAIN_W-1:0]        kd;
    logic signed [CORR_W-1:0] corr_lo;
    logic signed [CORR_W-1:0] corr_hi;
    logic [MOTOR_W-1:0]       motor_lo;
    logic [MOTOR_W-1:0]       motor_hi;
  } regs_t;

  // register settings used by the directed table
  typedef enum logic [2:0] {
    KEEP,
    INVERTED,
    FULL_SCALE,
    ZERO_GAIN,
    INTEGRATE
  } preset_t;

  typedef struct packed {
    preset_t   preset;
    sample_t   smp;
    logic      has_ref;
    out_data_t ref_out;
  } dir_row_t;

  localparam out_data_t NO_REF = '0;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  qpid_in_if  in_ch ();
  qpid_out_if out_ch ();

  three_axis_pid_quad_x_mixer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: registers, per-axis integral and previous error
  // ---------------------------------------------------------------------------
  regs_t                   regs;
  logic signed [SUM_W-1:0] err_sum [NUM_AXES];
  logic signed [ERR_W-1:0] prev_err [NUM_AXES];

  // motor command sets still owed by the block, oldest first
  out_data_t motor_cmds_due [$];

  int unsigned mismatches   = 0;
  int unsigned samples_sent = 0;
  int unsigned cmds_checked = 0;
  int unsigned reg_writes   = 0;
  int unsigned quiet        = 0;
  // set during the back-to-back run: no idling on either side
  bit          calm         = 1'b0;

  // Directed table. Typed results only where obvious: reset defaults with zero
  // error, the first full-scale pitch step (clamps at +500), inverted limits
  // (low clamp and high motor clamp win) and zero gains (motors follow throttle).
  dir_row_t dir_table [DIR_ROWS] = '{
    '{KEEP, '{12'd1500, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b1,
      '{12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'sd0, 12'sd0, 12'sd0}},
    '{KEEP, '{12'd0, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b1,
      '{12'd1000, 12'd1000, 12'd1000, 12'd1000, 12'sd0, 12'sd0, 12'sd0}},
    '{KEEP, '{12'd4095, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b1,
      '{12'd2000, 12'd2000, 12'd2000, 12'd2000, 12'sd0, 12'sd0, 12'sd0}},
    '{KEEP, '{12'd1500, 16'sh8000, 16'sh0000, 16'sh0000}, 1'b1,
      '{12'd1000, 12'd1000, 12'd2000, 12'd2000, 12'sd500, 12'sd0, 12'sd0}},
    '{KEEP, '{12'd1500, 16'sh7FFF, 16'sh0000, 16'sh0000}, 1'b0, NO_REF},
    '{KEEP, '{12'd1500, 16'sh0000, 16'sh8000, 16'sh7FFF}, 1'b0, NO_REF},
    '{KEEP, '{12'hAAA, 16'sh55AA, 16'shAA55, 16'sh5A5A}, 1'b0, NO_REF},
    '{KEEP, '{12'h555, 16'sd1, -16'sd1, 16'sd1}, 1'b0, NO_REF},
    '{KEEP, '{12'd1500, -16'sd1, 16'sd1, -16'sd1}, 1'b0, NO_REF},
    '{INVERTED, '{12'd1500, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b1,
      '{12'd500, 12'd500, 12'd500, 12'd500, 12'sd300, 12'sd300, 12'sd300}},
    '{KEEP, '{12'd4095, 16'sh8000, 16'sh7FFF, 16'sd100}, 1'b1,
      '{12'd500, 12'd500, 12'd500, 12'd500, 12'sd300, 12'sd300, 12'sd300}},
    '{KEEP, '{12'd0, 16'sd12345, -16'sd2222, 16'sh8000}, 1'b1,
      '{12'd500, 12'd500, 12'd500, 12'd500, 12'sd300, 12'sd300, 12'sd300}},
    '{ZERO_GAIN, '{12'd4095, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b1,
      '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'sd0, 12'sd0, 12'sd0}},
    '{KEEP, '{12'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b1,
      '{12'd0, 12'd0, 12'd0, 12'd0, 12'sd0, 12'sd0, 12'sd0}},
    '{FULL_SCALE, '{12'd4095, 16'sh8000, 16'sh7FFF, 16'sh8000}, 1'b0, NO_REF},
    '{KEEP, '{12'd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF}, 1'b0, NO_REF},
    '{KEEP, '{12'd2048, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, NO_REF},
    '{KEEP, '{12'd4095, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, NO_REF},
    '{KEEP, '{12'd0, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, NO_REF},
    '{INTEGRATE, '{12'd1000, -16'sd300, 16'sd200, -16'sd1}, 1'b0, NO_REF},
    '{KEEP, '{12'd1000, 16'sd1, 16'sd1, 16'sd1}, 1'b0, NO_REF},
    '{KEEP, '{12'd3000, -16'sd1, -16'sd1, -16'sd1}, 1'b0, NO_REF},
    '{KEEP, '{12'd500, 16'sh7FFF, 16'sh8000, 16'sh0000}, 1'b0, NO_REF},
    '{KEEP, '{12'd1800, -16'sd77, 16'sd5, 16'sd33}, 1'b0, NO_REF}
  };

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One PID lane: error is minus the measurement, integral saturates at 32 bits,
  // Q16.16 sum floors once, then clamp high first and low last.
  function automatic logic signed [CORR_W-1:0] axis_correction(
      input int ax, input logic signed [MEAS_W-1:0] meas);
    longint err, acc, raw, corr;
    err = -longint'(meas);
    acc = longint'(err_sum[ax]) + err;
    if (acc > longint'(SUM_MAX)) acc = longint'(SUM_MAX);
    if (acc < longint'(SUM_MIN)) acc = longint'(SUM_MIN);
    raw = longint'(regs.kp) * err + longint'(regs.ki) * acc
        + longint'(regs.kd) * (err - longint'(prev_err[ax]));
    err_sum[ax]  = acc[SUM_W-1:0];
    prev_err[ax] = err[ERR_W-1:0];
    corr = raw >>> FRAC_W;
    if (corr > longint'($signed(regs.corr_hi))) corr = longint'($signed(regs.corr_hi));
    if (corr < longint'($signed(regs.corr_lo))) corr = longint'($signed(regs.corr_lo));
    return corr[CORR_W-1:0];
  endfunction

  // low clamp first, high clamp last: inverted limits give motor_hi
  function automatic logic [MOTOR_W-1:0] motor_limit(input longint v);
    if (v < longint'(regs.motor_lo)) v = longint'(regs.motor_lo);
    if (v > longint'(regs.motor_hi)) v = longint'(regs.motor_hi);
    return v[MOTOR_W-1:0];
  endfunction

  function automatic out_data_t predict_motor_cmd(input sample_t s);
    out_data_t o;
    longint    thr, p, r, y;
    thr = longint'(s.throttle);
    p   = longint'(axis_correction(0, s.pitch));
    r   = longint'(axis_correction(1, s.roll));
    y   = longint'(axis_correction(2, s.yaw));
    o.motor_front_left  = motor_limit(thr - p - r - y);
    o.motor_front_right = motor_limit(thr - p + r + y);
    o.motor_rear_right  = motor_limit(thr + p + r - y);
    o.motor_rear_left   = motor_limit(thr + p - r + y);
    o.pitch_trim        = p[CORR_W-1:0];
    o.roll_trim         = r[CORR_W-1:0];
    o.yaw_trim          = y[CORR_W-1:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic regs_t preset_regs(input preset_t p);
    regs_t v;
    v = regs;
    case (p)
      INVERTED: begin
        v = '{16'd256, 16'd0, 16'd1280, 12'sd300, -12'sd300, 12'd3000, 12'd500};
      end
      FULL_SCALE: begin
        v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 12'sh800, 12'sh7FF, 12'd0, 12'hFFF};
      end
      ZERO_GAIN: begin
        v = '{16'd0, 16'd0, 16'd0, 12'sh800, 12'sh7FF, 12'd0, 12'hFFF};
      end
      INTEGRATE: begin
        v = '{16'd256, 16'd128, 16'd0, 12'sh800, 12'sh7FF, 12'd0, 12'hFFF};
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  // mostly modest gains so corrections are not always pinned at a clamp
  function automatic regs_t random_regs();
    regs_t v;
    v.kp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
    v.ki = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 48));
    v.kd = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2048));
    if ($urandom_range(0, 7) == 0) begin
      // any order, inverted pairs included
      v.corr_lo  = 12'($urandom);
      v.corr_hi  = 12'($urandom);
      v.motor_lo = 12'($urandom);
      v.motor_hi = 12'($urandom);
    end else begin
      v.corr_lo  = 12'(-int'($urandom_range(0, 2048)));
      v.corr_hi  = 12'($urandom_range(0, 2047));
      v.motor_lo = 12'($urandom_range(0, 1500));
      v.motor_hi = 12'($urandom_range(1500, 4095));
    end
    return v;
  endfunction

  function automatic logic signed [MEAS_W-1:0] random_angle();
    case ($urandom_range(0, 5))
      0, 1: return 16'(int'($urandom_range(0, 1023)) - 512);
      2: return 16'(int'($urandom_range(0, 16383)) - 8192);
      3, 4: return 16'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.throttle = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                              : 12'($urandom_range(900, 2100));
    s.pitch = random_angle();
    s.roll  = random_angle();
    s.yaw   = random_angle();
    return s;
  endfunction

  // Present one sample, hold it until the transfer, then log what it must produce.
  // Valid stays high on return so back-to-back samples need no extra edge.
  task automatic send_sample(input sample_t s, input logic typed, input out_data_t typed_out);
    out_data_t want;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.throttle    <= s.throttle;
    in_ch.pitch_angle <= s.pitch;
    in_ch.roll_angle  <= s.roll;
    in_ch.yaw_rate    <= s.yaw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = predict_motor_cmd(s);
    motor_cmds_due.push_back(typed ? typed_out : want);
    samples_sent++;
  endtask

  // drop valid, wait for every owed result, then let the pipeline go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (motor_cmds_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_index_t idx, input logic [CFG_DAT_W-1:0] word);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    reg_writes++;
  endtask

  // write the whole register file while the block is idle
  task automatic load_regs(input regs_t v);
    settle();
    put_reg(CFG_PROP_GAIN, v.kp);
    put_reg(CFG_INTEG_GAIN, v.ki);
    put_reg(CFG_DERIV_GAIN, v.kd);
    // 12-bit registers keep only the low bits; junk above must be ignored
    put_reg(CFG_OUT_LOW, {4'($urandom), v.corr_lo});
    put_reg(CFG_OUT_HIGH, {4'($urandom), v.corr_hi});
    put_reg(CFG_MOTOR_LOW, {4'($urandom), v.motor_lo});
    put_reg(CFG_MOTOR_HIGH, {4'($urandom), v.motor_hi});
    cfg_we <= 1'b0;
    regs = v;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string what, input logic [11:0] want,
                             input logic [11:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%03h actual 0x%03h", $time, what, want, got);
    end
  endtask

  // sink side stalls at random except during the back-to-back run
  always @(posedge clk) begin
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : result_check
    out_data_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (motor_cmds_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transfer, expected none actual front_left 0x%03h",
                 $time, out_ch.motor_front_left);
      end else begin
        want = motor_cmds_due.pop_front();
        check_field("motor_front_left", want.motor_front_left, out_ch.motor_front_left);
        check_field("motor_front_right", want.motor_front_right, out_ch.motor_front_right);
        check_field("motor_rear_right", want.motor_rear_right, out_ch.motor_rear_right);
        check_field("motor_rear_left", want.motor_rear_left, out_ch.motor_rear_left);
        check_field("pitch_trim", want.pitch_trim, out_ch.pitch_trim);
        check_field("roll_trim", want.roll_trim, out_ch.roll_trim);
        check_field("yaw_trim", want.yaw_trim, out_ch.yaw_trim);
        cmds_checked++;
      end
    end
  end

  // hang detector: cycles in a row with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results owed", $time, QUIET_LIMIT,
               motor_cmds_due.size());
      $display("tb_three_axis_pid_quad_x_mixer failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    sample_t s;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_PROP_GAIN;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.throttle    <= '0;
    in_ch.pitch_angle <= '0;
    in_ch.roll_angle  <= '0;
    in_ch.yaw_rate    <= '0;
    regs = '{PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, OUT_LOW_RST, OUT_HIGH_RST,
             MOTOR_LOW_RST, MOTOR_HIGH_RST};
    for (int a = 0; a < NUM_AXES; a++) begin
      err_sum[a]  = '0;
      prev_err[a] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: reset defaults, extremes, inverted limits, zero and full gains
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].preset != KEEP) load_regs(preset_regs(dir_table[i].preset));
      send_sample(dir_table[i].smp, dir_table[i].has_ref, dir_table[i].ref_out);
    end

    // random: new register settings for each segment, state carries across
    for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
      load_regs(random_regs());
      for (int n = 0; n < SEGMENT_ITEMS; n++) send_sample(random_sample(), 1'b0, NO_REF);
    end

    // Back-to-back run, no idling: pitch error held at +32768 and roll at -32767
    // so both integrals grow steadily; then the signs flip and they unwind.
    load_regs('{16'd0, 16'd1, 16'd0, 12'sh800, 12'sh7FF, 12'd0, 12'hFFF});
    calm = 1'b1;
    for (int n = 0; n < SOAK_ITEMS + UNWIND_ITEMS; n++) begin
      s = random_sample();
      s.pitch = (n < SOAK_ITEMS) ? 16'sh8000 : 16'sh7FFF;
      s.roll  = (n < SOAK_ITEMS) ? 16'sh7FFF : 16'sh8000;
      send_sample(s, 1'b0, NO_REF);
    end
    settle();
    calm = 1'b0;

    $display("Summary: %0d samples sent, %0d motor command sets checked, %0d register writes",
             samples_sent, cmds_checked, reg_writes);
    $display("Covered directed extremes, clamp inversions, %0d random segments, %0d back-to-back",
             RAND_SEGMENTS, SOAK_ITEMS + UNWIND_ITEMS);
    if (mismatches == 0 && motor_cmds_due.size() == 0)
      $display("tb_three_axis_pid_quad_x_mixer passed");
    else
      $display("tb_three_axis_pid_quad_x_mixer failed");
    $finish;
  end

endmodule
